[sv/fqf_pkg.sv]
// ----------------------------------------------------------------------------
// fqf_pkg: shared definitions for the fraction-bit quantizer
// Float format constants, register indexes, width helpers and the control struct.
// ----------------------------------------------------------------------------
package fqf_pkg;

	localparam int FloatWidth = 64;
	localparam int ExpBits    = (FloatWidth == 64) ? 11 : 8;
	localparam int MantBits   = FloatWidth - 1 - ExpBits;
	localparam int ExpBias    = (1 << (ExpBits - 1)) - 1;
	localparam int DataWidth  = 64;
	localparam int CfgWidth   = 7;
	localparam int IdxWidth   = 1;
	localparam int MagWidth   = MantBits + 2;
	localparam int ShWidth    = $clog2(MagWidth + 1);

	localparam logic [IdxWidth-1:0] RegFractionBits = 1'd0;
	localparam logic [IdxWidth-1:0] RegRoundMode    = 1'd1;

	typedef struct packed {
		logic       pass;
		logic       tiny;
		logic       sign;
		logic [5:0] n;
		logic       mode;
	} ctrl_t;

endpackage

[sv/fqf_decode.sv]
// ----------------------------------------------------------------------------
// fqf_decode: field split and grid classification
// Finds the shift from the value's exponent to the grid and flags the
// pass-through and below-half-step cases.
// ----------------------------------------------------------------------------
module fqf_decode (
	input  logic [fqf_pkg::FloatWidth-1:0] x,
	input  logic [6:0]                     fraction_bits,
	input  logic                           round_mode,
	output fqf_pkg::ctrl_t                 ctrl,
	output logic [fqf_pkg::MantBits:0]     mant,
	output logic [fqf_pkg::ShWidth-1:0]    shift
);
	import fqf_pkg::*;

	logic [ExpBits-1:0]  e;
	logic [MantBits-1:0] frac;
	logic signed [ExpBits+2:0] d;

	always_comb begin
		e    = x[FloatWidth-2 -: ExpBits];
		frac = x[MantBits-1:0];
		mant = {(e != '0), frac};
		if (e == '0) begin
			d = (ExpBits+3)'(ExpBias + MantBits - 1) - (ExpBits+3)'(fraction_bits[5:0]);
		end else begin
			d = (ExpBits+3)'(ExpBias + MantBits) - (ExpBits+3)'(e)
				- (ExpBits+3)'(fraction_bits[5:0]);
		end
		ctrl.sign = x[FloatWidth-1];
		ctrl.n    = fraction_bits[5:0];
		ctrl.mode = round_mode;
		ctrl.pass = fraction_bits[6] || (e == '1) || (x[FloatWidth-2:0] == '0)
			|| (d <= 0);
		ctrl.tiny = (d > MantBits + 1);
		shift = ctrl.tiny || ctrl.pass ? '0 : ShWidth'(d);
	end
endmodule

[sv/fqf_round.sv]
// ----------------------------------------------------------------------------
// fqf_round: mantissa shift, rounding increment and re-encoding
// Produces the quantized pattern from the registered decode results.
// ----------------------------------------------------------------------------
module fqf_round (
	input  logic [fqf_pkg::FloatWidth-1:0] x,
	input  fqf_pkg::ctrl_t                 ctrl,
	input  logic [fqf_pkg::MantBits:0]     mant,
	input  logic [fqf_pkg::ShWidth-1:0]    shift,
	output logic [fqf_pkg::FloatWidth-1:0] y
);
	import fqf_pkg::*;

	logic [MagWidth-1:0] m, q, rem, half, norm;
	logic [ShWidth-1:0]  p;
	logic [ExpBits-1:0]  bexp;

	always_comb begin
		m    = MagWidth'(mant);
		q    = m >> shift;
		rem  = m & ((MagWidth'(1) << shift) - MagWidth'(1));
		half = (MagWidth'(1) << shift) >> 1;
		if (ctrl.tiny) begin
			q = (!ctrl.mode && ctrl.sign) ? MagWidth'(1) : '0;
		end else if (ctrl.mode) begin
			if (rem >= half) q = q + MagWidth'(1);
		end else if (ctrl.sign && rem != '0) begin
			q = q + MagWidth'(1);
		end
		p = '0;
		for (int i = 0; i < MagWidth; i++) begin
			if (q[i]) p = ShWidth'(i);
		end
		bexp = ExpBits'(int'(p) - int'(ctrl.n) + ExpBias);
		norm = (q << (MagWidth - 1 - int'(p)));
		if (ctrl.pass) begin
			y = x;
		end else if (q == '0) begin
			y = {ctrl.sign, {(FloatWidth-1){1'b0}}};
		end else begin
			y = {ctrl.sign, bexp, norm[MagWidth-2 -: MantBits]};
		end
	end
endmodule

[sv/float_quantize_to_fraction_bits.sv]
// ----------------------------------------------------------------------------
// float_quantize_to_fraction_bits: quantize floats to a binary fraction grid
// Top level with configuration registers and two pipeline stages, the
// second of which is the output register.
// ----------------------------------------------------------------------------
// Usage: configuration is written through wr_en, wr_index and wr_data while
// the block is idle. Register 0 is the signed fraction bit count (negative
// passes values through) and register 1 the rounding mode.
// Input values arrive as stream transfers on s_tvalid, s_tready, s_tdata;
// results leave on m_tvalid, m_tready, m_tdata in the same order.
// One transfer can be accepted every cycle unless the receiver stalls.
// Each value is decoded into the stage register and then rounded into the
// output register, which drives m_tdata and m_tvalid.
// When the receiver stalls, the stages hold and s_tready falls only once
// both stages are occupied. Reset empties the pipeline and sets the fraction
// bit count to -1 and the mode to floor.
// ----------------------------------------------------------------------------
module float_quantize_to_fraction_bits (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [fqf_pkg::IdxWidth-1:0]    wr_index,
	input  logic [fqf_pkg::CfgWidth-1:0]    wr_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [fqf_pkg::DataWidth-1:0]   s_tdata,  // value_bits
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [fqf_pkg::DataWidth-1:0]   m_tdata   // quantized_bits
);
	import fqf_pkg::*;

	logic [6:0]  fraction_bits_q;
	logic        round_mode_q;
	logic        valid_s1, valid_s2;
	ctrl_t       ctrl_d, ctrl_s1;
	logic [MantBits:0] mant_d, mant_s1;
	logic [ShWidth-1:0] shift_d, shift_s1;
	logic [FloatWidth-1:0] x_s1, y_d, y_s2;
	logic adv1, adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fraction_bits_q <= 7'h7f;
			round_mode_q    <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == RegFractionBits) fraction_bits_q <= wr_data;
			else                             round_mode_q    <= wr_data[0];
		end
	end

	fqf_decode u_decode (
		.x(s_tdata[FloatWidth-1:0]), .fraction_bits(fraction_bits_q),
		.round_mode(round_mode_q), .ctrl(ctrl_d), .mant(mant_d), .shift(shift_d)
	);

	assign adv2     = !valid_s2 || m_tready;
	assign adv1     = !valid_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= s_tvalid;
			if (adv2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			x_s1     <= s_tdata[FloatWidth-1:0];
			ctrl_s1  <= ctrl_d;
			mant_s1  <= mant_d;
			shift_s1 <= shift_d;
		end
		if (adv2 && valid_s1) y_s2 <= y_d;
	end

	fqf_round u_round (
		.x(x_s1), .ctrl(ctrl_s1), .mant(mant_s1), .shift(shift_s1), .y(y_d)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = DataWidth'(y_s2);
endmodule

[sv/fqf_checker.sv]
// ----------------------------------------------------------------------------
// fqf_checker: port-level checks for the quantizer
// Watches the stream handshakes and result delivery at the top level.
// ----------------------------------------------------------------------------
module fqf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped under stall");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input blocked with empty output");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after two cycles");
endmodule

bind float_quantize_to_fraction_bits fqf_checker u_fqf_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[tb/sv/float_quantize_to_fraction_bits_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_quantize_to_fraction_bits_tb: self-checking bench for the quantizer
// Drives binary64 values through the stream input under several fraction bit
// counts and both rounding modes, predicts each quantized value in integer
// arithmetic and compares every output transfer in order.
// ----------------------------------------------------------------------------
module float_quantize_to_fraction_bits_tb;
	import fqf_pkg::*;

	localparam logic [63:0] PosInf  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NegZero = 64'h8000_0000_0000_0000;
	localparam logic [63:0] QNan    = 64'h7FF8_0000_0000_0001;
	localparam logic [63:0] NoCheck = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MaxDbl  = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MinSub  = 64'h0000_0000_0000_0001;
	localparam int CycleLimit = 400000;

	typedef struct {
		logic [6:0]  nbits;
		logic        mode;
		logic [63:0] value;
		logic [63:0] result;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [IdxWidth-1:0] wr_index = '0;
	logic [CfgWidth-1:0] wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DataWidth-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DataWidth-1:0] m_tdata;

	logic [6:0] cur_nbits = 7'h7F;
	logic cur_mode = 1'b0;
	logic [63:0] pending_q[$];
	logic [63:0] sample_q[$];
	int errors = 0;
	int cycles = 0;
	int rdy_wait = 0;
	int rdy_draw;
	bit stim_done = 0;
	vec_t vecs[$];

	float_quantize_to_fraction_bits dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [63:0] pack_grid(logic [63:0] sgn, logic [63:0] q, int n);
		int p;
		logic [63:0] mant;
		if (q == 0)
			return sgn;
		p = 63;
		while (p > 0 && q[p] == 1'b0)
			p--;
		if (p <= MantBits)
			mant = q << (MantBits - p);
		else
			mant = q >> (p - MantBits);
		mant &= (64'd1 << MantBits) - 1;
		return sgn | (64'(p - n + ExpBias) << MantBits) | mant;
	endfunction

	function automatic logic [63:0] quantize(logic [63:0] x);
		logic [63:0] sgn, frac, m, q, rem;
		int e, n, d;
		sgn = x & NegZero;
		e = int'(x[62:52]);
		frac = {12'd0, x[51:0]};
		if (cur_nbits[6])
			return x;
		n = int'(cur_nbits[5:0]);
		if (e == 2047 || (e == 0 && frac == 0))
			return x;
		if (e == 0) begin
			m = frac;
			d = ExpBias + MantBits - 1 - n;
		end else begin
			m = frac | (64'd1 << MantBits);
			d = ExpBias + MantBits - e - n;
		end
		if (d <= 0)
			return x;
		if (d > MantBits + 1)
			return pack_grid(sgn, (cur_mode || sgn == 0) ? 64'd0 : 64'd1, n);
		q = m >> d;
		rem = m & ((64'd1 << d) - 1);
		if (cur_mode) begin
			if (rem >= (64'd1 << (d - 1)))
				q++;
		end else if (sgn != 0 && rem != 0) begin
			q++;
		end
		return pack_grid(sgn, q, n);
	endfunction

	task automatic write_reg(logic [IdxWidth-1:0] idx, logic [6:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		if (idx == RegFractionBits)
			cur_nbits = val;
		else
			cur_mode = val[0];
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(logic [6:0] nb, logic md);
		drain();
		write_reg(RegFractionBits, nb);
		write_reg(RegRoundMode, {6'd0, md});
		wr_en <= 1'b0;
	endtask

	task automatic send_value(logic [63:0] v, logic [63:0] given);
		logic [63:0] pred;
		int idle;
		idle = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0);
		if (idle != 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		pred = quantize(v);
		if (given != NoCheck && given != pred) begin
			$display("%0t: table mismatch for %h: expected %h, predicted %h",
				$time, v, given, pred);
			errors++;
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		pending_q.push_back(pred);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v[62:52] = 11'(ExpBias - 60 + $urandom_range(0, 12));
			1: v[62:52] = 11'(ExpBias + 40 + $urandom_range(0, 20));
			2: v[62:52] = $urandom_range(0, 1) ? 11'd0 : 11'h7FF;
			3: v[51:0] = v[51:0] & ~((52'd1 << $urandom_range(0, 52)) - 1);
			default: v[62:52] = 11'(ExpBias - 8 + $urandom_range(0, 16));
		endcase
		return v;
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected transfer: expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				if (pending_q[0] !== m_tdata) begin
					$display("%0t: mismatch: expected %h, actual %h",
						$time, pending_q[0], m_tdata);
					errors++;
				end
				void'(pending_q.pop_front());
			end
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			rdy_draw = stim_done ? 0 : $urandom_range(0, 9);
			rdy_wait <= rdy_draw;
			m_tready <= (rdy_draw == 0);
		end else if (rdy_wait != 0) begin
			rdy_wait <= rdy_wait - 1;
			m_tready <= (rdy_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int t;
		vecs = '{
			'{7'h7F, 1'b0, 64'h3FF8_0000_0000_0000, 64'h3FF8_0000_0000_0000},
			'{7'h7F, 1'b0, QNan, QNan},
			'{7'd0, 1'b0, 64'h3FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000},
			'{7'd0, 1'b0, 64'hBFF8_0000_0000_0000, 64'hC000_0000_0000_0000},
			'{7'd0, 1'b0, PosInf, PosInf},
			'{7'd0, 1'b0, NegZero, NegZero},
			'{7'd0, 1'b0, MaxDbl, MaxDbl},
			'{7'd0, 1'b0, MinSub, 64'd0},
			'{7'd0, 1'b0, MinSub | NegZero, 64'hBFF0_0000_0000_0000},
			'{7'd0, 1'b1, 64'h3FF8_0000_0000_0000, 64'h4000_0000_0000_0000},
			'{7'd0, 1'b1, 64'hBFE0_0000_0000_0000, 64'hBFF0_0000_0000_0000},
			'{7'd0, 1'b1, 64'hBFD0_0000_0000_0000, NegZero},
			'{7'd0, 1'b1, 64'hFFF0_0000_0000_0000, 64'hFFF0_0000_0000_0000},
			'{7'd60, 1'b1, 64'h3FF0_0000_0000_0001, NoCheck},
			'{7'd60, 1'b0, 64'hBC40_0000_0000_0001, NoCheck},
			'{7'd60, 1'b0, 64'h3C30_0000_0000_0000, 64'h3C30_0000_0000_0000},
			'{7'd3, 1'b1, 64'h3FC3_3333_3333_3333, NoCheck},
			'{7'd3, 1'b0, 64'hC009_2222_2222_2222, NoCheck},
			'{7'd52, 1'b1, 64'h0010_0000_0000_0001, NoCheck},
			'{7'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vecs[i]) begin
			if (vecs[i].nbits != cur_nbits || vecs[i].mode != cur_mode)
				set_config(vecs[i].nbits, vecs[i].mode);
			send_value(vecs[i].value, vecs[i].result);
		end
		for (int k = 0; k < 1800; k++) begin
			if (k % 150 == 0) begin
				t = $urandom_range(0, 7);
				set_config(t == 0 ? 7'h7F : t == 1 ? 7'd60 : t == 2 ? 7'd0 :
					7'($urandom_range(0, 60)), 1'($urandom_range(0, 1)));
			end
			if (k % 150 == 75)
				drain();
			send_value(rand_value(), NoCheck);
		end
		stim_done = 1;
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
sv/fqf_pkg.sv
sv/fqf_decode.sv
sv/fqf_round.sv
sv/float_quantize_to_fraction_bits.sv
sv/fqf_checker.sv
tb/sv/float_quantize_to_fraction_bits_tb.sv
